// ===== hdl/bpdec_pkg.sv =====
// ----------------------------------------------------------------------------
// Beeper audio decimator package
// Shared constants, configuration register indexes and pipeline control types.
// ----------------------------------------------------------------------------
package bpdec_pkg;

  // Default tap divider of the beeper port, applied to CPU transactions.
  localparam int unsigned CyclesPerTapDef = 8;

  // Taps summed into one audio sample.
  localparam int unsigned TapsPerSample = 11;

  // Widths of the payload fields.
  localparam int unsigned AddrW   = 16;
  localparam int unsigned PortW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 8;
  localparam int unsigned TapCntW = 4;
  localparam int unsigned CfgIdxW = 2;

  // Scaling constants. The tap sum is centred by subtracting the offset,
  // multiplied by 16, divided by 11 and multiplied by 120.
  localparam int unsigned TapOffset = 15;
  localparam int unsigned ScaleMul  = 120;

  // Reciprocal of 11 in 16 fractional bits. Exact for dividends below 4096.
  localparam int unsigned Recip11     = 5958;
  localparam int unsigned Recip11Frac = 16;

  // Reciprocal of 5 in 20 fractional bits. Exact for dividends below 2**17.
  localparam int unsigned Recip5     = 209716;
  localparam int unsigned Recip5Frac = 20;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgExitAddr   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReloadAddr = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartAddr  = 2'd2;

  // Control flags that travel alongside each transaction through the pipeline.
  typedef struct packed {
    logic restart;   // clears the filter state when it reaches the last stage
    logic sample;    // this transaction completes a sample
    logic reload;    // reload breakpoint entered
    logic finished;  // exit breakpoint has been reached
  } ctl_t;

endpackage

// ===== hdl/beeper_audio_decimator.sv =====
// ----------------------------------------------------------------------------
// Beeper audio decimator
// Watches the program counter of an emulated CPU for exit and reload
// breakpoints and decimates the beeper port into filtered 16-bit samples.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                   Payload
//  -------  ---------  --------------------------  ------------------------------
//  in       input      in_valid_i / in_stall_o     action, pc_now, port_byte
//  out      output     out_valid_o / out_stall_i   sample_valid, audio_sample,
//                                                  reload_request, finished
//  cfg      input      cfg_valid_i / cfg_ready_o   cfg_index, cfg_data
//
// One transaction is accepted per clock cycle unless the input is stalled; every
// input transaction gives exactly one output transaction through the five
// register stages of the scaling and filter datapath (three constant multipliers,
// each followed by a register). Reset is asynchronous and active low; it clears
// the breakpoint state, the counters, the filter and all three address registers.
// A stall on the output fills the pipeline stage by stage before the input
// is stalled. The configuration port never stalls.
//
module beeper_audio_decimator #(
  parameter int unsigned CYCLES_PER_TAP = bpdec_pkg::CyclesPerTapDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [bpdec_pkg::AddrW-1:0]        pc_now_i,
  input  logic [bpdec_pkg::PortW-1:0]        port_byte_i,

  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               sample_valid_o,
  output logic signed [bpdec_pkg::SampleW-1:0] audio_sample_o,
  output logic                               reload_request_o,
  output logic                               finished_o,

  // Configuration channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bpdec_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bpdec_pkg::AddrW-1:0]        cfg_data_i
);

  localparam int unsigned CycCntW = (CYCLES_PER_TAP > 1) ? $clog2(CYCLES_PER_TAP) : 1;
  localparam logic [CycCntW-1:0] CycLast = CycCntW'(CYCLES_PER_TAP - 1);
  localparam logic [bpdec_pkg::TapCntW-1:0] TapLast =
    bpdec_pkg::TapCntW'(bpdec_pkg::TapsPerSample - 1);

  localparam int unsigned AW = bpdec_pkg::AddrW;
  localparam int unsigned SW = bpdec_pkg::SampleW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [AW-1:0] exit_addr_q, reload_addr_q, start_addr_q;

  assign cfg_ready_o = 1'b1;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_addr_q   <= '0;
      reload_addr_q <= '0;
      start_addr_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpdec_pkg::CfgExitAddr:   exit_addr_q   <= cfg_data_i;
        bpdec_pkg::CfgReloadAddr: reload_addr_q <= cfg_data_i;
        bpdec_pkg::CfgStartAddr:  start_addr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic in_accept;

  assign rdy_out   = !out_valid_q || !out_stall_i;
  assign rdy4      = !v4_q || rdy_out;
  assign rdy3      = !v3_q || rdy4;
  assign rdy2      = !v2_q || rdy3;
  assign rdy1      = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_accept = in_valid_i && rdy1;

  // --------------------------------------------------------------------------
  // Breakpoint and decimation state
  // --------------------------------------------------------------------------
  logic [AW-1:0]                     prev_pc_q, prev_pc_d;
  logic [CycCntW-1:0]                cyc_cnt_q, cyc_cnt_d;
  logic [bpdec_pkg::TapCntW-1:0]     tap_cnt_q, tap_cnt_d;
  logic [bpdec_pkg::SumW-1:0]        tap_sum_q, tap_sum_d;
  logic                              halted_q, halted_d;

  logic [bpdec_pkg::SumW-1:0]        tap_val, sum_new, sum_out;
  bpdec_pkg::ctl_t                   ctl0;

  // Port bit 4 is worth 16 and bit 3 is worth 1.
  assign tap_val = {3'b000, port_byte_i[4], 3'b000, port_byte_i[3]};
  assign sum_new = tap_sum_q + tap_val;

  // Next state for one CPU cycle or a restart.
  always_comb begin
    prev_pc_d = prev_pc_q;
    cyc_cnt_d = cyc_cnt_q;
    tap_cnt_d = tap_cnt_q;
    tap_sum_d = tap_sum_q;
    halted_d  = halted_q;
    sum_out   = sum_new;
    ctl0      = '0;
    if (action_i) begin
      prev_pc_d    = start_addr_q;
      cyc_cnt_d    = '0;
      tap_cnt_d    = '0;
      tap_sum_d    = '0;
      halted_d     = 1'b0;
      ctl0.restart = 1'b1;
    end else if (!halted_q) begin
      if (pc_now_i == exit_addr_q) begin
        halted_d = 1'b1;
      end else begin
        ctl0.reload = (pc_now_i == reload_addr_q) && (pc_now_i != prev_pc_q);
        prev_pc_d   = pc_now_i;
        if (cyc_cnt_q == CycLast) begin
          cyc_cnt_d = '0;
          if (tap_cnt_q == TapLast) begin
            ctl0.sample = 1'b1;
            tap_cnt_d   = '0;
            tap_sum_d   = '0;
          end else begin
            tap_cnt_d = tap_cnt_q + 1'b1;
            tap_sum_d = sum_new;
          end
        end else begin
          cyc_cnt_d = cyc_cnt_q + 1'b1;
        end
      end
    end
    ctl0.finished = halted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pc_q <= '0;
      cyc_cnt_q <= '0;
      tap_cnt_q <= '0;
      tap_sum_q <= '0;
      halted_q  <= 1'b0;
    end else if (in_accept) begin
      prev_pc_q <= prev_pc_d;
      cyc_cnt_q <= cyc_cnt_d;
      tap_cnt_q <= tap_cnt_d;
      tap_sum_q <= tap_sum_d;
      halted_q  <= halted_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: control flags and completed tap sum
  // --------------------------------------------------------------------------
  bpdec_pkg::ctl_t             ctl1_q;
  logic [bpdec_pkg::SumW-1:0]  sum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ctl1_q <= ctl0;
      sum1_q <= sum_out;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: centre the sum, scale by 16 and divide by 11 (truncating)
  // --------------------------------------------------------------------------
  logic signed [bpdec_pkg::SumW:0]   diff1;
  logic                              neg1;
  logic [bpdec_pkg::SumW-1:0]        mag1;
  logic [11:0]                       m16_1;
  logic [24:0]                       prod11;

  bpdec_pkg::ctl_t  ctl2_q;
  logic             neg2_q;
  logic [7:0]       q11_2_q;

  assign diff1  = $signed({1'b0, sum1_q}) - $signed(9'(bpdec_pkg::TapOffset));
  assign neg1   = diff1[bpdec_pkg::SumW];
  assign mag1   = neg1 ? bpdec_pkg::SumW'(-diff1) : bpdec_pkg::SumW'(diff1);
  assign m16_1  = {mag1[7:0], 4'b0000};
  assign prod11 = 25'(m16_1) * 25'(bpdec_pkg::Recip11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      ctl2_q  <= ctl1_q;
      neg2_q  <= neg1;
      q11_2_q <= prod11[bpdec_pkg::Recip11Frac +: 8];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: multiply by 120 and restore the sign
  // --------------------------------------------------------------------------
  logic [14:0]             xmag2;
  logic signed [SW-1:0]    x2;

  bpdec_pkg::ctl_t         ctl3_q;
  logic signed [SW-1:0]    x3_q;

  assign xmag2 = 15'(q11_2_q) * 15'(bpdec_pkg::ScaleMul);
  assign x2    = neg2_q ? -$signed({1'b0, xmag2}) : $signed({1'b0, xmag2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      ctl3_q <= ctl2_q;
      x3_q   <= x2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: filter step (x - prev) * 8 / 10, as (|x - prev| * 4) / 5
  // --------------------------------------------------------------------------
  // Samples are at least eleven transactions apart, so the filter value read
  // here is never one still in flight in the next stage.
  logic signed [SW-1:0]  filter_q;
  logic signed [SW:0]    d3;
  logic                  dneg3;
  logic [SW-1:0]         dmag3;
  logic [16:0]           m4_3;
  logic [34:0]           prod5;

  bpdec_pkg::ctl_t       ctl4_q;
  logic                  neg4_q;
  logic [14:0]           q5_4_q;

  assign d3    = {x3_q[SW-1], x3_q} - {filter_q[SW-1], filter_q};
  assign dneg3 = d3[SW];
  assign dmag3 = dneg3 ? SW'(-d3) : SW'(d3);
  assign m4_3  = {dmag3[14:0], 2'b00};
  assign prod5 = 35'(m4_3) * 35'(bpdec_pkg::Recip5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      ctl4_q <= ctl3_q;
      neg4_q <= dneg3;
      q5_4_q <= prod5[bpdec_pkg::Recip5Frac +: 15];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: new filter value and result register
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] step4, f4;
  logic                 fwd4;

  logic                 sample_valid_q, reload_q, finished_q;
  logic signed [SW-1:0] audio_q;

  assign step4 = neg4_q ? -$signed({1'b0, q5_4_q}) : $signed({1'b0, q5_4_q});
  assign f4    = filter_q + step4;
  assign fwd4  = v4_q && rdy_out;

  // The filter is updated by a sample and cleared by a restart, in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= '0;
    end else if (fwd4) begin
      if (ctl4_q.restart) begin
        filter_q <= '0;
      end else if (ctl4_q.sample) begin
        filter_q <= f4;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd4) begin
      sample_valid_q <= ctl4_q.sample;
      audio_q        <= ctl4_q.sample ? f4 : '0;
      reload_q       <= ctl4_q.reload;
      finished_q     <= ctl4_q.finished;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_valid_o   = sample_valid_q;
  assign audio_sample_o   = audio_q;
  assign reload_request_o = reload_q;
  assign finished_o       = finished_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result without a sample carries a zero sample field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> audio_sample_o == '0)
    else $error("audio sample not zero without a new sample");

  // Emitted samples stay within the range that the scaling allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |->
      ($signed(audio_sample_o) >= -16'sd2520) && ($signed(audio_sample_o) <= 16'sd30000))
    else $error("audio sample out of range");

  // A restart loads the start address and clears the halt flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && action_i |=> !halted_q && (prev_pc_q == $past(start_addr_q)))
    else $error("restart did not reinitialise the breakpoint state");

  // Once halted, plain CPU transactions leave the block halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !action_i && halted_q |=> halted_q)
    else $error("halt flag dropped without a restart");

  // The tap counter never passes the last tap of a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_cnt_q <= TapLast)
    else $error("tap counter out of range");

endmodule
